@@ hw/rtl/ihcs_pkg.sv @@
// Package with shared types and constants for the image header canvas sniffer.
`timescale 1ns / 1ps
package ihcs_pkg;
    localparam int unsigned HeaderBytesDefault = 32;
    localparam logic [63:0] StillLimitReset = 64'd40000000;
    localparam logic [23:0] ScanCeilingReset = 24'd4194304;
    localparam logic [23:0] PosMax = 24'hFFFFFF;

    localparam logic [2:0] FmtUnknown = 3'd0;
    localparam logic [2:0] FmtPng = 3'd1;
    localparam logic [2:0] FmtGif = 3'd2;
    localparam logic [2:0] FmtWebp = 3'd3;
    localparam logic [2:0] FmtJpeg = 3'd4;

    localparam logic RegStillLimit = 1'b0;
    localparam logic RegScanCeiling = 1'b1;

    typedef struct packed {
        logic [31:0] factor_a;
        logic [31:0] factor_b;
        logic scaled;
        logic [2:0] fmt;
    } t_classify;
endpackage

@@ hw/rtl/ihcs_jpeg_walk.sv @@
// JPEG marker walk that skips segments and captures the SOF frame size.
`timescale 1ns / 1ps
module ihcs_jpeg_walk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_clear,
    input  logic [7:0]  i_byte,
    input  logic [23:0] i_pos,
    input  logic [7:0]  i_first_byte,
    input  logic [23:0] i_ceiling,
    output logic        o_answer_given,
    output logic [15:0] o_height,
    output logic [15:0] o_width
);
    import ihcs_pkg::*;

    typedef enum logic [3:0] {
        PH_HEADER, PH_MARK0, PH_MARK1, PH_LEN0, PH_LEN1, PH_SKIP,
        PH_SOF0, PH_SOF1, PH_SOF2, PH_SOF3, PH_SOF4, PH_DONE, PH_FAIL
    } t_phase;

    t_phase r_phase, n_phase;
    logic [7:0] r_marker, n_marker;
    logic [15:0] r_len, n_len, r_skip, n_skip, r_height, n_height;
    logic r_answer, n_answer;
    logic [15:0] w_len_full;
    logic w_frame;

    assign w_len_full = {r_len[15:8], i_byte};
    assign w_frame = (r_marker[7:4] == 4'hC) && (r_marker != 8'hC4)
        && (r_marker != 8'hC8) && (r_marker != 8'hCC);

    always_comb begin
        n_phase = r_phase;
        n_marker = r_marker;
        n_len = r_len;
        n_skip = r_skip;
        n_height = r_height;
        n_answer = r_answer;
        unique case (r_phase)
            PH_HEADER: begin
                if (i_pos == 24'd1 && i_first_byte == 8'hFF && i_byte == 8'hD8) begin
                    n_phase = PH_MARK0;
                end
            end
            PH_MARK0: begin
                n_phase = (i_pos >= i_ceiling || i_byte != 8'hFF) ? PH_FAIL : PH_MARK1;
            end
            PH_MARK1: begin
                n_marker = i_byte;
                if (i_byte == 8'hD8 || i_byte == 8'h01 || i_byte[7:3] == 5'b11010) begin
                    n_phase = PH_MARK0;
                end else begin
                    n_phase = PH_LEN0;
                end
            end
            PH_LEN0: begin
                n_len = {i_byte, 8'h00};
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_len = w_len_full;
                if (w_len_full < 16'd2) begin
                    n_phase = PH_FAIL;
                end else if (w_frame) begin
                    n_phase = PH_SOF0;
                end else begin
                    n_skip = w_len_full - 16'd2;
                    n_phase = (w_len_full == 16'd2) ? PH_MARK0 : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (r_skip == 16'd1) begin
                    n_phase = PH_MARK0;
                end
            end
            PH_SOF0: n_phase = PH_SOF1;
            PH_SOF1: begin
                n_height = {i_byte, 8'h00};
                n_phase = PH_SOF2;
            end
            PH_SOF2: begin
                n_height = {r_height[15:8], i_byte};
                n_phase = PH_SOF3;
            end
            PH_SOF3: begin
                n_len = {i_byte, 8'h00};
                n_phase = PH_SOF4;
            end
            PH_SOF4: begin
                n_len = w_len_full;
                n_answer = 1'b1;
                n_phase = PH_DONE;
            end
            default: n_phase = r_phase;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_HEADER;
            r_marker <= 8'h00;
            r_len <= 16'h0000;
            r_skip <= 16'h0000;
            r_height <= 16'h0000;
            r_answer <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_marker <= n_marker;
            r_len <= n_len;
            r_skip <= n_skip;
            r_height <= n_height;
            r_answer <= n_answer;
        end
    end

    assign o_answer_given = r_answer;
    assign o_height = r_height;
    assign o_width = r_len;

`ifndef SYNTHESIS
    a_answer_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_answer |-> r_phase == PH_DONE) else $error("answer without done phase");
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_skip != 16'd0) else $error("skip count zero in skip");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> r_phase == PH_HEADER && !r_answer) else $error("clear failed");
`endif
endmodule

@@ hw/rtl/image_header_canvas_sniffer.sv @@
// Top level of the image header canvas sniffer.
//
// Words arrive on the input channel: func 0 carries one file byte, func 1 ends
// the file. Each end-of-file word yields exactly one result word; bytes yield none.
// A new word is accepted every cycle while input ready is high.
// At end of file the header is classified in the input cycle, the two
// factors are registered, the product is registered after them and the
// result is then written into the output queue.
// The 32x32 multiplier stage sets the depth of the result path.
// A four-entry queue at the output holds results while the receiver stalls.
// Input ready drops only when the queued results plus those still in the pipeline
// would fill it, so while results drain, end-of-file words can come every cycle.
// Reset clears per-file state and the configuration registers to
// their defaults; the header store itself is not cleared, since unwritten
// bytes are never examined once the byte count is checked.
// Configuration words are taken at any time and must arrive while idle.
`timescale 1ns / 1ps
module image_header_canvas_sniffer #(
    parameter int unsigned HEADER_BYTES = ihcs_pkg::HeaderBytesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_canvas_pixels,
    output logic        o_decodes_scaled,
    output logic        o_over_budget,
    output logic [2:0]  o_format_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import ihcs_pkg::*;

    localparam int unsigned Aw = $clog2(HEADER_BYTES);

    logic [7:0] r_hdr [HEADER_BYTES];
    logic [23:0] r_pos;
    logic [63:0] r_limit;
    logic [23:0] r_ceiling;
    logic w_acc, w_byte, w_eof;
    logic w_ans;
    logic [15:0] w_h, w_w;
    t_classify n_cls, r_cls;
    logic r_s1_v;
    logic [63:0] r_px;
    logic r_scaled, r_s2_v;
    logic [2:0] r_fmt;
    logic [68:0] r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic w_rd, w_wr;
    logic [68:0] w_res;
    logic [68:0] w_head;
    logic w_over;

    assign w_acc = i_valid && o_ready;
    assign w_byte = w_acc && !i_func;
    assign w_eof = w_acc && i_func;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= StillLimitReset;
            r_ceiling <= ScanCeilingReset;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == RegStillLimit) begin
                r_limit <= i_cfg_data;
            end else begin
                r_ceiling <= i_cfg_data[23:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_byte && r_pos < 24'(HEADER_BYTES)) begin
            r_hdr[r_pos[Aw-1:0]] <= i_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_eof) begin
            r_pos <= 24'd0;
        end else if (w_byte && r_pos != PosMax) begin
            r_pos <= r_pos + 24'd1;
        end
    end

    ihcs_jpeg_walk u_walk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_byte), .i_clear(w_eof),
        .i_byte(i_byte_value), .i_pos(r_pos), .i_first_byte(r_hdr[0]),
        .i_ceiling(r_ceiling), .o_answer_given(w_ans), .o_height(w_h), .o_width(w_w)
    );

    function automatic logic [7:0] hb(input int unsigned at, input logic [23:0] n);
        hb = (n > 24'(at)) ? r_hdr[at] : 8'h00;
    endfunction

    always_comb begin
        logic [47:0] gif;
        logic [31:0] vl;
        logic [7:0] b27, b29;
        logic png, gif_ok, webp;
        png = r_pos >= 24'd24 && hb(0, r_pos) == 8'h89 && hb(1, r_pos) == 8'h50
            && hb(2, r_pos) == 8'h4E && hb(3, r_pos) == 8'h47 && hb(4, r_pos) == 8'h0D
            && hb(5, r_pos) == 8'h0A && hb(6, r_pos) == 8'h1A && hb(7, r_pos) == 8'h0A
            && {hb(12, r_pos), hb(13, r_pos), hb(14, r_pos), hb(15, r_pos)} == "IHDR";
        gif = {hb(0, r_pos), hb(1, r_pos), hb(2, r_pos), hb(3, r_pos), hb(4, r_pos),
            hb(5, r_pos)};
        gif_ok = r_pos >= 24'd10 && (gif == "GIF87a" || gif == "GIF89a");
        webp = r_pos >= 24'd30
            && {hb(0, r_pos), hb(1, r_pos), hb(2, r_pos), hb(3, r_pos)} == "RIFF"
            && {hb(8, r_pos), hb(9, r_pos), hb(10, r_pos), hb(11, r_pos)} == "WEBP";
        vl = {hb(24, r_pos), hb(23, r_pos), hb(22, r_pos), hb(21, r_pos)};
        b27 = hb(27, r_pos);
        b29 = hb(29, r_pos);
        n_cls = '0;
        if (png) begin
            n_cls.fmt = FmtPng;
            n_cls.factor_a = {hb(16, r_pos), hb(17, r_pos), hb(18, r_pos), hb(19, r_pos)};
            n_cls.factor_b = {hb(20, r_pos), hb(21, r_pos), hb(22, r_pos), hb(23, r_pos)};
        end else if (gif_ok) begin
            n_cls.fmt = FmtGif;
            n_cls.factor_a = {16'h0, hb(7, r_pos), hb(6, r_pos)};
            n_cls.factor_b = {16'h0, hb(9, r_pos), hb(8, r_pos)};
        end else if (webp) begin
            n_cls.fmt = FmtWebp;
            if ({hb(12, r_pos), hb(13, r_pos), hb(14, r_pos), hb(15, r_pos)} == "VP8X") begin
                n_cls.factor_a = 32'({hb(26, r_pos), hb(25, r_pos), hb(24, r_pos)}) + 32'd1;
                n_cls.factor_b = 32'({hb(29, r_pos), hb(28, r_pos), hb(27, r_pos)}) + 32'd1;
            end else if ({hb(12, r_pos), hb(13, r_pos), hb(14, r_pos), hb(15, r_pos)}
                    == "VP8 ") begin
                n_cls.factor_a = {18'h0, b27[5:0], hb(26, r_pos)};
                n_cls.factor_b = {18'h0, b29[5:0], hb(28, r_pos)};
            end else if ({hb(12, r_pos), hb(13, r_pos), hb(14, r_pos), hb(15, r_pos)}
                    == "VP8L") begin
                n_cls.factor_a = 32'(vl[13:0]) + 32'd1;
                n_cls.factor_b = 32'(vl[27:14]) + 32'd1;
            end
        end else if (r_pos >= 24'd2 && hb(0, r_pos) == 8'hFF && hb(1, r_pos) == 8'hD8) begin
            n_cls.fmt = FmtJpeg;
            n_cls.scaled = 1'b1;
            if (w_ans) begin
                n_cls.factor_a = {16'h0, w_h};
                n_cls.factor_b = {16'h0, w_w};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_eof;
            r_s2_v <= r_s1_v;
        end
        r_cls <= n_cls;
        r_px <= 64'(r_cls.factor_a) * 64'(r_cls.factor_b);
        r_scaled <= r_cls.scaled;
        r_fmt <= r_cls.fmt;
    end

    assign w_over = !r_scaled && r_px != 64'd0 && r_px > r_limit;
    assign w_res = {r_px, r_scaled, w_over, r_fmt};
    assign w_wr = r_s2_v;
    assign w_rd = o_valid && i_ready;

    // Queued results and those still in the pipeline must all fit in the queue.
    assign o_ready = (r_cnt + 3'(r_s1_v) + 3'(r_s2_v)) < 3'd4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_wp <= 2'd0;
            r_rp <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 3'(w_wr) - 3'(w_rd);
            if (w_wr) r_wp <= r_wp + 2'd1;
            if (w_rd) r_rp <= r_rp + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_res;
        end
    end

    assign w_head = r_q[r_rp];
    assign o_valid = r_cnt != 3'd0;
    assign o_canvas_pixels = w_head[68:5];
    assign o_decodes_scaled = w_head[4];
    assign o_over_budget = w_head[3];
    assign o_format_code = w_head[2:0];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("output queue overflow");
    a_eof_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eof |=> ##1 r_s2_v) else $error("result lost in pipeline");
    a_scaled_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_decodes_scaled |-> !o_over_budget) else $error("scaled over budget");
`endif
endmodule

@@ dv/image_header_canvas_sniffer_test.sv @@
// Testbench that checks the image header canvas sniffer against its own predictor.
`timescale 1ns / 1ps
module image_header_canvas_sniffer_test;
    import ihcs_pkg::*;

    typedef enum logic [3:0] {
        PhHeader, PhMark0, PhMark1, PhLen0, PhLen1, PhSkip,
        PhSof0, PhSof1, PhSof2, PhSof3, PhSof4, PhDone, PhFail
    } t_walk_phase;

    typedef struct {
        logic [63:0] pixels;
        logic        scaled;
        logic        over;
        logic [2:0]  fmt;
    } t_canvas;

    localparam logic [63:0] LimitTop = 64'hFFFF_FFFE_0000_0001;
    localparam int SettleCycles = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_func;
    logic [7:0]  i_byte_value;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_canvas_pixels;
    logic        o_decodes_scaled;
    logic        o_over_budget;
    logic [2:0]  o_format_code;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;

    image_header_canvas_sniffer dut (.*);

    // Predictor state.
    logic [63:0] pr_limit;
    logic [23:0] pr_ceiling;
    logic [7:0]  pr_store [32];
    logic [23:0] pr_pos;
    t_walk_phase pr_phase;
    logic [7:0]  pr_marker;
    logic [15:0] pr_seglen;
    logic [15:0] pr_skip;
    logic [15:0] pr_height;
    logic        pr_found;

    t_canvas     canvas_q[$];
    logic [7:0]  file_q[$];
    int          errors;
    int          results_seen;
    int          burst_left;
    int          gap_max;
    int          rcv_count;
    int          rcv_mode;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void clear_file();
        for (int i = 0; i < 32; i++) pr_store[i] = 8'h00;
        pr_pos = '0;
        pr_phase = PhHeader;
        pr_marker = '0;
        pr_seglen = '0;
        pr_skip = '0;
        pr_height = '0;
        pr_found = 1'b0;
    endfunction

    function automatic bit store_is(int at, string s);
        for (int i = 0; i < s.len(); i++) begin
            if (pr_store[at + i] != s[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] le16(int at);
        return {48'd0, pr_store[at + 1], pr_store[at]};
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        logic [23:0] pos;
        pos = pr_pos;
        if (pos < 32) pr_store[pos] = b;
        case (pr_phase)
            PhHeader: if (pos == 1 && pr_store[0] == 8'hFF && b == 8'hD8) pr_phase = PhMark0;
            PhMark0: pr_phase = (pos >= pr_ceiling || b != 8'hFF) ? PhFail : PhMark1;
            PhMark1: begin
                pr_marker = b;
                if (b == 8'hD8 || b == 8'h01 || (b >= 8'hD0 && b <= 8'hD7)) pr_phase = PhMark0;
                else pr_phase = PhLen0;
            end
            PhLen0: begin
                pr_seglen = {b, 8'h00};
                pr_phase = PhLen1;
            end
            PhLen1: begin
                pr_seglen[7:0] = b;
                if (pr_seglen < 2) begin
                    pr_phase = PhFail;
                end else if (pr_marker[7:4] == 4'hC && pr_marker != 8'hC4
                             && pr_marker != 8'hC8 && pr_marker != 8'hCC) begin
                    pr_phase = PhSof0;
                end else begin
                    pr_skip = pr_seglen - 16'd2;
                    pr_phase = (pr_skip == 0) ? PhMark0 : PhSkip;
                end
            end
            PhSkip: begin
                pr_skip = pr_skip - 16'd1;
                if (pr_skip == 0) pr_phase = PhMark0;
            end
            PhSof0: pr_phase = PhSof1;
            PhSof1: begin
                pr_height = {b, 8'h00};
                pr_phase = PhSof2;
            end
            PhSof2: begin
                pr_height[7:0] = b;
                pr_phase = PhSof3;
            end
            PhSof3: begin
                pr_seglen = {b, 8'h00};
                pr_phase = PhSof4;
            end
            PhSof4: begin
                pr_seglen[7:0] = b;
                pr_found = 1'b1;
                pr_phase = PhDone;
            end
            default: ;
        endcase
        if (pr_pos != PosMax) pr_pos = pr_pos + 24'd1;
    endfunction

    function automatic t_canvas predict_canvas();
        t_canvas c;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] packed_word;
        a = '0;
        b = '0;
        c.fmt = FmtUnknown;
        c.scaled = 1'b0;
        if (pr_pos >= 24 && pr_store[0] == 8'h89 && store_is(1, "PNG")
            && pr_store[4] == 8'h0D && pr_store[5] == 8'h0A && pr_store[6] == 8'h1A
            && pr_store[7] == 8'h0A && store_is(12, "IHDR")) begin
            c.fmt = FmtPng;
            a = {32'd0, pr_store[16], pr_store[17], pr_store[18], pr_store[19]};
            b = {32'd0, pr_store[20], pr_store[21], pr_store[22], pr_store[23]};
        end else if (pr_pos >= 10 && (store_is(0, "GIF87a") || store_is(0, "GIF89a"))) begin
            c.fmt = FmtGif;
            a = le16(6);
            b = le16(8);
        end else if (pr_pos >= 30 && store_is(0, "RIFF") && store_is(8, "WEBP")) begin
            c.fmt = FmtWebp;
            if (store_is(12, "VP8X")) begin
                a = 64'd1 + (le16(24) | {40'd0, pr_store[26], 16'd0});
                b = 64'd1 + (le16(27) | {40'd0, pr_store[29], 16'd0});
            end else if (store_is(12, "VP8 ")) begin
                a = le16(26) & 64'h3FFF;
                b = le16(28) & 64'h3FFF;
            end else if (store_is(12, "VP8L")) begin
                packed_word = le16(21) | (le16(23) << 16);
                a = (packed_word & 64'h3FFF) + 64'd1;
                b = ((packed_word >> 14) & 64'h3FFF) + 64'd1;
            end
        end else if (pr_pos >= 2 && pr_store[0] == 8'hFF && pr_store[1] == 8'hD8) begin
            c.fmt = FmtJpeg;
            c.scaled = 1'b1;
            if (pr_found) begin
                a = {48'd0, pr_height};
                b = {48'd0, pr_seglen};
            end
        end
        c.pixels = a * b;
        c.over = !c.scaled && c.pixels != 0 && c.pixels > pr_limit;
        return c;
    endfunction

    always @(negedge i_clk) begin
        rcv_count <= rcv_count + 1;
        if (rcv_count % 97 == 0) rcv_mode <= $urandom_range(0, 3);
        case (rcv_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= (rcv_count % 4) != 0;
            2: i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= (rcv_count % 32) < 6;
        endcase
    end

    always @(posedge i_clk) begin
        t_canvas want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (canvas_q.size() == 0) begin
                $display("%0t: result with none expected: pixels %0d fmt %0d", $time,
                         o_canvas_pixels, o_format_code);
                errors++;
            end else begin
                want = canvas_q.pop_front();
                if (o_canvas_pixels !== want.pixels) begin
                    $display("%0t: canvas_pixels expected %0d actual %0d", $time,
                             want.pixels, o_canvas_pixels);
                    errors++;
                end
                if (o_decodes_scaled !== want.scaled) begin
                    $display("%0t: decodes_scaled expected %0d actual %0d", $time,
                             want.scaled, o_decodes_scaled);
                    errors++;
                end
                if (o_over_budget !== want.over) begin
                    $display("%0t: over_budget expected %0d actual %0d", $time,
                             want.over, o_over_budget);
                    errors++;
                end
                if (o_format_code !== want.fmt) begin
                    $display("%0t: format_code expected %0d actual %0d", $time,
                             want.fmt, o_format_code);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(logic f, logic [7:0] b);
        if (burst_left <= 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(0, gap_max)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_valid = 1'b1;
        i_func = f;
        i_byte_value = b;
        do @(posedge i_clk); while (!o_ready);
        if (f) begin
            canvas_q.push_back(predict_canvas());
            clear_file();
        end else begin
            predict_byte(b);
        end
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic send_file();
        foreach (file_q[i]) send_word(1'b0, file_q[i]);
        send_word(1'b1, 8'($urandom_range(0, 255)));
        file_q.delete();
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (canvas_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == RegStillLimit) pr_limit = data;
        else pr_ceiling = data[23:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
    endtask

    task automatic put_rnd(int n);
        repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] dim_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic put_dims(int n);
        repeat (n) file_q.push_back(dim_byte());
    endtask

    task automatic build_png();
        file_q = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
        put_rnd(4);
        put_str("IHDR");
        put_dims(8);
        put_rnd($urandom_range(0, 6));
    endtask

    task automatic build_gif();
        put_str($urandom_range(0, 1) ? "GIF89a" : "GIF87a");
        put_dims(4);
        put_rnd($urandom_range(0, 6));
    endtask

    task automatic build_webp();
        put_str("RIFF");
        put_rnd(4);
        put_str("WEBP");
        case ($urandom_range(0, 3))
            0: put_str("VP8X");
            1: put_str("VP8 ");
            2: put_str("VP8L");
            default: put_rnd(4);
        endcase
        put_dims($urandom_range(14, 20));
    endtask

    task automatic build_jpeg();
        logic [7:0] code;
        int len;
        file_q = '{8'hFF, 8'hD8};
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 5))
                0: begin
                    file_q.push_back(8'hFF);
                    case ($urandom_range(0, 2))
                        0: file_q.push_back(8'h01);
                        1: file_q.push_back(8'hD8);
                        default: file_q.push_back(8'($urandom_range(8'hD0, 8'hD7)));
                    endcase
                end
                1: begin
                    file_q.push_back(8'hFF);
                    case ($urandom_range(0, 2))
                        0: file_q.push_back(8'hC4);
                        1: file_q.push_back(8'hC8);
                        default: file_q.push_back(8'hCC);
                    endcase
                    len = $urandom_range(2, 6);
                    file_q.push_back(8'h00);
                    file_q.push_back(8'(len));
                    put_rnd(len - 2);
                end
                2: begin
                    file_q.push_back(8'hFF);
                    file_q.push_back(8'($urandom_range(8'hE0, 8'hFE)));
                    len = $urandom_range(0, 16) == 0 ? $urandom_range(0, 1)
                                                     : $urandom_range(2, 9);
                    file_q.push_back(8'h00);
                    file_q.push_back(8'(len));
                    if (len >= 2) put_rnd(len - 2);
                end
                3: if ($urandom_range(0, 3) == 0) put_rnd(2);
                default: ;
            endcase
        end
        do code = 8'($urandom_range(8'hC0, 8'hCF));
        while (code == 8'hC4 || code == 8'hC8 || code == 8'hCC);
        file_q.push_back(8'hFF);
        file_q.push_back(code);
        put_rnd(2);
        file_q.push_back(8'h08);
        put_dims(4);
        put_rnd($urandom_range(0, 5));
    endtask

    task automatic build_random_file();
        int idx;
        case ($urandom_range(0, 9))
            0, 1: build_png();
            2: build_gif();
            3, 4: build_webp();
            5, 6, 7: build_jpeg();
            default: put_rnd($urandom_range(0, 40));
        endcase
        if ($urandom_range(0, 5) == 0 && file_q.size() > 0) begin
            idx = $urandom_range(0, file_q.size() - 1);
            while (file_q.size() > idx) void'(file_q.pop_back());
        end
        if ($urandom_range(0, 7) == 0 && file_q.size() > 0) begin
            idx = $urandom_range(0, file_q.size() - 1);
            file_q[idx] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic test_empty_and_noise();
        send_file();
        put_rnd(3);
        send_file();
    endtask

    task automatic test_png_extremes();
        file_q = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
        put_rnd(4);
        put_str("IHDR");
        repeat (8) file_q.push_back(8'hFF);
        send_file();
    endtask

    task automatic test_gif_and_webp();
        put_str("GIF87a");
        file_q.push_back(8'h40);
        file_q.push_back(8'h1F);
        file_q.push_back(8'h00);
        file_q.push_back(8'h20);
        send_file();
        put_str("RIFF");
        put_rnd(4);
        put_str("WEBPVP8X");
        repeat (14) file_q.push_back(8'hFF);
        send_file();
    endtask

    task automatic test_jpeg_walk();
        file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hD0, 8'hFF, 8'h01, 8'hFF, 8'hC4, 8'h00, 8'h03,
                   8'h55, 8'hFF, 8'hC2, 8'h00, 8'h00, 8'h08, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'h12};
        send_file();
    endtask

    task automatic test_random_phases();
        int phase_results;
        int phase_items;
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(RegStillLimit, 64'd0);
                    write_reg(RegScanCeiling, 64'd2);
                end
                1: begin
                    write_reg(RegStillLimit, LimitTop);
                    write_reg(RegScanCeiling, 64'hFF_FFFF);
                end
                2: begin
                    write_reg(RegStillLimit, {$urandom, $urandom} % (LimitTop + 64'd1));
                    write_reg(RegScanCeiling, 64'($urandom_range(3, 30)));
                end
                default: begin
                    write_reg(RegStillLimit, 64'($urandom_range(0, 32'h00FF_FFFF)));
                    write_reg(RegScanCeiling, 64'($urandom_range(2, 24'hFF_FFFF)));
                end
            endcase
            gap_max = (ph == 4) ? 0 : $urandom_range(1, 6);
            phase_results = 0;
            phase_items = 0;
            while (phase_results < 8 || phase_items < 100) begin
                build_random_file();
                phase_items += file_q.size() + 1;
                phase_results++;
                send_file();
                if (ph == 2 && phase_results == 4) wait_idle();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = 1'b0;
        i_byte_value = 8'h00;
        i_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = RegStillLimit;
        i_cfg_data = '0;
        rcv_count = 0;
        rcv_mode = 0;
        errors = 0;
        results_seen = 0;
        burst_left = 0;
        gap_max = 3;
        pr_limit = StillLimitReset;
        pr_ceiling = ScanCeilingReset;
        clear_file();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_and_noise();
        test_png_extremes();
        test_gif_and_webp();
        test_jpeg_walk();
        test_random_phases();

        i_valid = 1'b0;
        fork
            while (canvas_q.size() != 0) @(posedge i_clk);
            repeat (200000) @(posedge i_clk);
        join_any
        disable fork;
        repeat (SettleCycles) @(posedge i_clk);
        if (errors == 0 && canvas_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (canvas_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, canvas_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/ihcs_pkg.sv
hw/rtl/ihcs_jpeg_walk.sv
hw/rtl/image_header_canvas_sniffer.sv
dv/image_header_canvas_sniffer_test.sv
